>>> design/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg: shared types and constants for the midpoint ellipse rasterizer
// Holds the default field widths, operation codes, controller states, the
// datapath command set and the status bundle returned to the controller.
// ----------------------------------------------------------------------------
package mer_pkg;

  // Default field widths
  localparam int RADIUS_BITS_DEF = 10;
  localparam int COORD_BITS_DEF  = 12;

  // Operation codes carried on the input channel
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RX2,
    ST_RY2,
    ST_RXRY,
    ST_INIT_FIN,
    ST_SW_TX1,
    ST_SW_TX2,
    ST_SW_TY1,
    ST_SW_TY2,
    ST_SW_RR,
    ST_SW_DEC,
    ST_STEP_FIN
  } mer_state_t;

  // Datapath commands, one per cycle
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,      // capture radii and center of a start item
    CMD_RX2,        // rx * rx
    CMD_RY2,        // ry * ry
    CMD_RXRY,       // rx^2 * ry
    CMD_INIT_EMIT,  // load start values, send first point set
    CMD_TX1,        // ry^2 * (2x+1)
    CMD_TX2,        // ... * (2x+1)
    CMD_TY1,        // rx^2 * (y-1), park first term
    CMD_TY2,        // ... * (y-1)
    CMD_RR,         // rx^2 * ry^2, accumulate second term
    CMD_SW_DEC,     // load region-two decision value
    CMD_STEP_EMIT,  // advance one point, send point set
    CMD_IDLE_EMIT   // send empty result for a step with nothing in progress
  } mer_cmd_t;

  // Status bundle from datapath to controller
  typedef struct packed {
    logic busy;         // an ellipse is in progress
    logic need_switch;  // next step crosses into region two
    logic slot_free;    // output register can take a result this cycle
  } mer_status_t;

endpackage

>>> design/mer_ctrl.sv
// ----------------------------------------------------------------------------
// mer_ctrl: sequencing state machine
// Accepts input items, walks the multiply sequences for start and for the
// region change, and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module mer_ctrl
  import mer_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        operation,
  input  mer_status_t status,
  output mer_cmd_t    cmd
);

  mer_state_t state_r, state_nxt;
  logic       accept;

  assign accept = in_tvalid && in_tready;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_START) begin
            state_nxt = ST_RX2;
          end else if (status.busy && status.need_switch) begin
            state_nxt = ST_SW_TX1;
          end
        end
      end
      ST_RX2:      state_nxt = ST_RY2;
      ST_RY2:      state_nxt = ST_RXRY;
      ST_RXRY:     state_nxt = ST_INIT_FIN;
      ST_INIT_FIN: if (status.slot_free) state_nxt = ST_IDLE;
      ST_SW_TX1:   state_nxt = ST_SW_TX2;
      ST_SW_TX2:   state_nxt = ST_SW_TY1;
      ST_SW_TY1:   state_nxt = ST_SW_TY2;
      ST_SW_TY2:   state_nxt = ST_SW_RR;
      ST_SW_RR:    state_nxt = ST_SW_DEC;
      ST_SW_DEC:   state_nxt = ST_STEP_FIN;
      ST_STEP_FIN: if (status.slot_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: ready and command
  always_comb begin
    in_tready = 1'b0;
    cmd       = CMD_NONE;
    case (state_r)
      ST_IDLE: begin
        in_tready = status.slot_free;
        if (in_tvalid && status.slot_free) begin
          if (operation == OP_START) begin
            cmd = CMD_LATCH;
          end else if (!status.busy) begin
            cmd = CMD_IDLE_EMIT;
          end else if (!status.need_switch) begin
            cmd = CMD_STEP_EMIT;
          end
        end
      end
      ST_RX2:      cmd = CMD_RX2;
      ST_RY2:      cmd = CMD_RY2;
      ST_RXRY:     cmd = CMD_RXRY;
      ST_INIT_FIN: cmd = status.slot_free ? CMD_INIT_EMIT : CMD_NONE;
      ST_SW_TX1:   cmd = CMD_TX1;
      ST_SW_TX2:   cmd = CMD_TX2;
      ST_SW_TY1:   cmd = CMD_TY1;
      ST_SW_TY2:   cmd = CMD_TY2;
      ST_SW_RR:    cmd = CMD_RR;
      ST_SW_DEC:   cmd = CMD_SW_DEC;
      ST_STEP_FIN: cmd = status.slot_free ? CMD_STEP_EMIT : CMD_NONE;
      default:     cmd = CMD_NONE;
    endcase
  end

  // Results are only written into a free output register
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_INIT_EMIT || cmd == CMD_STEP_EMIT || cmd == CMD_IDLE_EMIT)
      |-> status.slot_free)
    else $error("result issued while output register is occupied");

  // A step is only taken on an ellipse in progress
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_STEP_EMIT) |-> status.busy)
    else $error("step issued with no ellipse in progress");

  // The region change always ends in a step
  a_sw_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SW_DEC) |=> (state_r == ST_STEP_FIN))
    else $error("region change did not finish with a step");

endmodule

>>> design/mer_datapath.sv
// ----------------------------------------------------------------------------
// mer_datapath: ellipse state, shared multiplier and output register
// Holds the offsets, slope terms and scaled decision value, runs one shared
// multiplier under command control and updates the walk one point per step.
// ----------------------------------------------------------------------------
module mer_datapath
  import mer_pkg::*;
#(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mer_cmd_t                      cmd,
  output mer_status_t                   status,
  input  logic [RADIUS_BITS-1:0]        radius_x,
  input  logic [RADIUS_BITS-1:0]        radius_y,
  input  logic signed [COORD_BITS-1:0]  center_x,
  input  logic signed [COORD_BITS-1:0]  center_y,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic                          valid_res,
  output logic signed [COORD_BITS:0]    right_x,
  output logic signed [COORD_BITS:0]    left_x,
  output logic signed [COORD_BITS:0]    upper_y,
  output logic signed [COORD_BITS:0]    lower_y,
  output logic                          final_res
);

  localparam int SQ_W    = 2 * RADIUS_BITS;
  localparam int SLOPE_W = 3 * RADIUS_BITS + 2;
  localparam int DEC_W   = 4 * RADIUS_BITS + 8;
  localparam int T_W     = 4 * RADIUS_BITS + 2;
  localparam int MA_W    = 3 * RADIUS_BITS + 1;
  localparam int MB_W    = 2 * RADIUS_BITS;
  localparam int P_W     = MA_W + MB_W;
  localparam int OUT_W   = COORD_BITS + 1;
  localparam int SUM_W   = ((RADIUS_BITS > COORD_BITS) ? RADIUS_BITS : COORD_BITS) + 2;

  // Control state
  logic busy_r, region2_r, out_valid_r;
  // Ellipse state
  logic [RADIUS_BITS-1:0] rx_r, ry_r, x_r, y_r;
  logic [SQ_W-1:0]        a_r, b_r;
  logic [SLOPE_W-1:0]     fx_r, fy_r;
  logic [DEC_W-1:0]       dec_r, acc_r;
  logic [T_W-1:0]         t_r;
  logic [COORD_BITS-1:0]  cx_r, cy_r;
  // Output payload
  logic                   out_vres_r, out_final_r;
  logic [OUT_W-1:0]       out_rx_r, out_lx_r, out_uy_r, out_ly_r;

  logic                   emit;
  logic                   slot_free;
  logic [MA_W-1:0]        mul_a;
  logic [MB_W-1:0]        mul_b;
  logic [P_W-1:0]         prod;
  logic [RADIUS_BITS:0]   tx;
  logic [RADIUS_BITS-1:0] ty;

  logic [SLOPE_W-1:0]     fx_inc, fy_dec;
  logic                   dec_neg, dec_pos;
  logic [RADIUS_BITS-1:0] x_step, y_step;
  logic [SLOPE_W-1:0]     fx_step, fy_step;
  logic [DEC_W-1:0]       dec_step, dec_init;
  logic [RADIUS_BITS-1:0] pos_x, pos_y;
  logic [SUM_W-1:0]       cx_ext, cy_ext, px_ext, py_ext;
  logic [SUM_W-1:0]       rx_sum, lx_sum, uy_sum, ly_sum;

  assign emit = (cmd == CMD_INIT_EMIT) || (cmd == CMD_STEP_EMIT) || (cmd == CMD_IDLE_EMIT);
  assign slot_free = !out_valid_r || out_tready;

  assign status.busy        = busy_r;
  assign status.need_switch = !region2_r && !(fx_r < fy_r);
  assign status.slot_free   = slot_free;

  // Region-change factors: 2x+1 and y-1
  assign tx = {x_r, 1'b1};
  assign ty = y_r - 1'b1;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd)
      CMD_RX2:  begin mul_a = MA_W'(rx_r);        mul_b = MB_W'(rx_r); end
      CMD_RY2:  begin mul_a = MA_W'(ry_r);        mul_b = MB_W'(ry_r); end
      CMD_RXRY: begin mul_a = MA_W'(a_r);         mul_b = MB_W'(ry_r); end
      CMD_TX1:  begin mul_a = MA_W'(b_r);         mul_b = MB_W'(tx);   end
      CMD_TX2:  begin mul_a = t_r[MA_W-1:0];      mul_b = MB_W'(tx);   end
      CMD_TY1:  begin mul_a = MA_W'(a_r);         mul_b = MB_W'(ty);   end
      CMD_TY2:  begin mul_a = t_r[MA_W-1:0];      mul_b = MB_W'(ty);   end
      CMD_RR:   begin mul_a = MA_W'(a_r);         mul_b = b_r;         end
      default:  begin mul_a = '0;                 mul_b = '0;          end
    endcase
  end

  assign prod = P_W'(mul_a) * P_W'(mul_b);

  // Start values: decision = 4*ry^2 - 4*rx^2*ry + rx^2, t holds rx^2*ry
  assign dec_init = (DEC_W'(b_r) << 2) - (DEC_W'(t_r) << 2) + DEC_W'(a_r);

  // One point of the walk
  assign fx_inc  = fx_r + SLOPE_W'({b_r, 1'b0});
  assign fy_dec  = fy_r - SLOPE_W'({a_r, 1'b0});
  assign dec_neg = dec_r[DEC_W-1];
  assign dec_pos = !dec_neg && (dec_r != '0);

  always_comb begin
    if (!region2_r) begin
      x_step  = x_r + 1'b1;
      fx_step = fx_inc;
      if (dec_neg) begin
        y_step   = y_r;
        fy_step  = fy_r;
        dec_step = dec_r + ((DEC_W'(fx_inc) + DEC_W'(b_r)) << 2);
      end else begin
        y_step   = y_r - 1'b1;
        fy_step  = fy_dec;
        dec_step = dec_r + ((DEC_W'(fx_inc) - DEC_W'(fy_dec) + DEC_W'(b_r)) << 2);
      end
    end else begin
      y_step  = y_r - 1'b1;
      fy_step = fy_dec;
      if (dec_pos) begin
        x_step   = x_r;
        fx_step  = fx_r;
        dec_step = dec_r + ((DEC_W'(a_r) - DEC_W'(fy_dec)) << 2);
      end else begin
        x_step   = x_r + 1'b1;
        fx_step  = fx_inc;
        dec_step = dec_r + ((DEC_W'(fx_inc) - DEC_W'(fy_dec) + DEC_W'(a_r)) << 2);
      end
    end
  end

  // Mirror the offset about the center
  assign pos_x  = (cmd == CMD_INIT_EMIT) ? '0   : x_step;
  assign pos_y  = (cmd == CMD_INIT_EMIT) ? ry_r : y_step;
  assign cx_ext = {{(SUM_W-COORD_BITS){cx_r[COORD_BITS-1]}}, cx_r};
  assign cy_ext = {{(SUM_W-COORD_BITS){cy_r[COORD_BITS-1]}}, cy_r};
  assign px_ext = {{(SUM_W-RADIUS_BITS){1'b0}}, pos_x};
  assign py_ext = {{(SUM_W-RADIUS_BITS){1'b0}}, pos_y};
  assign rx_sum = cx_ext + px_ext;
  assign lx_sum = cx_ext - px_ext;
  assign uy_sum = cy_ext + py_ext;
  assign ly_sum = cy_ext - py_ext;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      region2_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        CMD_INIT_EMIT: begin
          busy_r    <= (ry_r != '0);
          region2_r <= 1'b0;
        end
        CMD_STEP_EMIT: busy_r    <= (y_step != '0);
        CMD_SW_DEC:    region2_r <= 1'b1;
        default:       ;
      endcase
    end
  end

  // Ellipse state and multiplier destinations
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LATCH: begin
        rx_r <= radius_x;
        ry_r <= radius_y;
        cx_r <= center_x;
        cy_r <= center_y;
      end
      CMD_RX2:  a_r <= prod[SQ_W-1:0];
      CMD_RY2:  b_r <= prod[SQ_W-1:0];
      CMD_RXRY: t_r <= prod[T_W-1:0];
      CMD_INIT_EMIT: begin
        x_r   <= '0;
        y_r   <= ry_r;
        fx_r  <= '0;
        fy_r  <= SLOPE_W'({t_r, 1'b0});
        dec_r <= dec_init;
      end
      CMD_TX1:  t_r <= prod[T_W-1:0];
      CMD_TX2:  t_r <= prod[T_W-1:0];
      CMD_TY1: begin
        acc_r <= DEC_W'(t_r);
        t_r   <= prod[T_W-1:0];
      end
      CMD_TY2:  t_r <= prod[T_W-1:0];
      CMD_RR: begin
        acc_r <= acc_r + (DEC_W'(t_r) << 2);
        t_r   <= prod[T_W-1:0];
      end
      CMD_SW_DEC: dec_r <= acc_r - (DEC_W'(t_r) << 2);
      CMD_STEP_EMIT: begin
        x_r   <= x_step;
        y_r   <= y_step;
        fx_r  <= fx_step;
        fy_r  <= fy_step;
        dec_r <= dec_step;
      end
      default: ;
    endcase
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (cmd == CMD_IDLE_EMIT) begin
      out_vres_r  <= 1'b0;
      out_final_r <= 1'b0;
      out_rx_r    <= '0;
      out_lx_r    <= '0;
      out_uy_r    <= '0;
      out_ly_r    <= '0;
    end else if (emit) begin
      out_vres_r  <= 1'b1;
      out_final_r <= (pos_y == '0);
      out_rx_r    <= rx_sum[OUT_W-1:0];
      out_lx_r    <= lx_sum[OUT_W-1:0];
      out_uy_r    <= uy_sum[OUT_W-1:0];
      out_ly_r    <= ly_sum[OUT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign valid_res  = out_vres_r;
  assign final_res  = out_final_r;
  assign right_x    = out_rx_r;
  assign left_x     = out_lx_r;
  assign upper_y    = out_uy_r;
  assign lower_y    = out_ly_r;

  // An ellipse in progress never sits on its last row
  a_busy_row: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (y_r != '0))
    else $error("ellipse in progress with vertical offset zero");

  // Loading the region-two decision value leaves a live ellipse in region two
  a_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_SW_DEC) |=> (region2_r && busy_r))
    else $error("region change lost the ellipse");

  // A final point set is always a valid one
  a_final_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_final_r) |-> out_vres_r)
    else $error("final flag on an empty result");

endmodule

>>> design/midpoint_ellipse_rasterizer_top.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_top: axis-aligned midpoint ellipse rasterizer
// Walks the first quadrant of an ellipse and sends four mirrored pixels
// per point, with a controller and a datapath around one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser is the operation (0 start, 1 step); in_tdata
//   carries radius_x, radius_y, center_x, center_y (read on start only).
//   Output stream: one item per input item. out_tuser is valid_res, out_tlast
//   marks the final point set, out_tdata the four mirrored coordinates.
//   A step with no ellipse in progress answers with valid_res low and zeros.
// Timing:
//   An ordinary step's point set is registered in the cycle the step is taken,
//   so steps run at one per cycle while the output register is free. A start
//   runs three multiplies of the shared multiplier plus load; for the step
//   that crosses into region two, five multiplies build the region-two
//   decision value. Results sit in an output register; the next item is taken
//   only while it is empty or its result is read in that same cycle.
// Reset and stall:
//   rst_n (synchronous, active low) drops any ellipse and empties the output.
//   A stalled receiver holds the output; input is not taken until it frees.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_top
  import mer_pkg::*;
#(
  parameter  int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter  int COORD_BITS  = COORD_BITS_DEF,
  localparam int IN_DATA_W   = ((2 * RADIUS_BITS + 2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W  = ((4 * (COORD_BITS + 1) + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // radius_x, radius_y, center_x, center_y (lowest bits first), zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // right_x, left_x, upper_y, lower_y (lowest bits first), zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // valid_res
  output logic                  out_tuser,
  // final_res
  output logic                  out_tlast
);

  localparam int OUT_W = COORD_BITS + 1;
  localparam int RY_LO = RADIUS_BITS;
  localparam int CX_LO = 2 * RADIUS_BITS;
  localparam int CY_LO = 2 * RADIUS_BITS + COORD_BITS;

  mer_cmd_t                    cmd;
  mer_status_t                 status;
  logic [RADIUS_BITS-1:0]      radius_x, radius_y;
  logic signed [COORD_BITS-1:0] center_x, center_y;
  logic signed [OUT_W-1:0]     right_x, left_x, upper_y, lower_y;

  // Unpack input fields
  assign radius_x = in_tdata[RADIUS_BITS-1:0];
  assign radius_y = in_tdata[RY_LO +: RADIUS_BITS];
  assign center_x = in_tdata[CX_LO +: COORD_BITS];
  assign center_y = in_tdata[CY_LO +: COORD_BITS];

  // Pack output fields
  assign out_tdata = OUT_DATA_W'({lower_y, upper_y, left_x, right_x});

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .operation (in_tuser),
    .status    (status),
    .cmd       (cmd)
  );

  mer_datapath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .radius_x   (radius_x),
    .radius_y   (radius_y),
    .center_x   (center_x),
    .center_y   (center_y),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .valid_res  (out_tuser),
    .right_x    (right_x),
    .left_x     (left_x),
    .upper_y    (upper_y),
    .lower_y    (lower_y),
    .final_res  (out_tlast)
  );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the midpoint ellipse rasterizer
// Feeds start and step items through the input stream and checks every
// point set on the output stream against the table or an internal tracer
// of the ellipse walk. A directed table comes first, then random ellipses
// of mostly small radii, under three idle patterns and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import mer_pkg::*;

  localparam int RB    = RADIUS_BITS_DEF;
  localparam int CB    = COORD_BITS_DEF;
  localparam int OB    = CB + 1;
  localparam int IN_W  = ((2 * RB + 2 * CB + 7) / 8) * 8;
  localparam int OUT_W = ((4 * OB + 7) / 8) * 8;

  // One point set as it leaves the block
  typedef struct packed {
    logic                 valid_res;
    logic signed [OB-1:0] right_x;
    logic signed [OB-1:0] left_x;
    logic signed [OB-1:0] upper_y;
    logic signed [OB-1:0] lower_y;
    logic                 final_res;
  } point_set_t;

  // One row of the directed plan
  typedef struct packed {
    logic          op;
    logic [RB-1:0] rx;
    logic [RB-1:0] ry;
    logic [CB-1:0] cx;
    logic [CB-1:0] cy;
    logic          typed;
    point_set_t    known;
  } plan_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // radius_x, radius_y, center_x, center_y, zero fill
  logic             in_tuser;   // operation
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // right_x, left_x, upper_y, lower_y, zero fill
  logic             out_tuser;  // valid_res
  logic             out_tlast;  // final_res

  // Tracer state: current offset, slope terms, 4x decision, squared radii
  logic [63:0] pen_x, pen_y;
  logic [63:0] grad_x, grad_y;
  logic [63:0] err_term;
  logic [63:0] rx_sq, ry_sq;
  logic [63:0] ctr_x, ctr_y;
  logic        lower_arc;
  logic        tracing;

  point_set_t pending_sets[$];
  plan_row_t  plan[$];
  point_set_t last_set;
  point_set_t seen;
  point_set_t want;
  int         mismatch_count = 0;
  int         items_sent = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         hold_req = 1'b0;

  midpoint_ellipse_rasterizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the ellipse walk by one item and return the point set it gives
  function automatic point_set_t trace_ellipse(input logic op,
                                               input logic [RB-1:0] rx,
                                               input logic [RB-1:0] ry,
                                               input logic [CB-1:0] cx,
                                               input logic [CB-1:0] cy);
    point_set_t  r;
    logic [63:0] tx, ty, sum;
    r = '0;
    if (op == OP_START) begin
      rx_sq     = 64'(rx) * 64'(rx);
      ry_sq     = 64'(ry) * 64'(ry);
      ctr_x     = {{(64-CB){cx[CB-1]}}, cx};
      ctr_y     = {{(64-CB){cy[CB-1]}}, cy};
      pen_x     = 64'd0;
      pen_y     = 64'(ry);
      grad_x    = 64'd0;
      grad_y    = 64'd2 * rx_sq * 64'(ry);
      err_term  = 64'd4 * ry_sq - 64'd4 * rx_sq * 64'(ry) + rx_sq;
      lower_arc = 1'b0;
      tracing   = 1'b1;
    end else if (!tracing) begin
      return r;
    end else if (!lower_arc && grad_x < grad_y) begin
      // Region one: x always moves, y moves when the decision is not negative
      pen_x  = pen_x + 64'd1;
      grad_x = grad_x + 64'd2 * ry_sq;
      if (err_term[63]) begin
        err_term = err_term + 64'd4 * (grad_x + ry_sq);
      end else begin
        pen_y    = pen_y - 64'd1;
        grad_y   = grad_y - 64'd2 * rx_sq;
        err_term = err_term + 64'd4 * (grad_x - grad_y + ry_sq);
      end
    end else begin
      // Crossing into region two reloads the decision at the midpoint
      if (!lower_arc) begin
        tx        = 64'd2 * pen_x + 64'd1;
        ty        = pen_y - 64'd1;
        err_term  = ry_sq * tx * tx + 64'd4 * rx_sq * ty * ty
                  - 64'd4 * rx_sq * ry_sq;
        lower_arc = 1'b1;
      end
      // Region two: y always moves, x moves when the decision is not positive
      pen_y  = pen_y - 64'd1;
      grad_y = grad_y - 64'd2 * rx_sq;
      if (!err_term[63] && err_term != 64'd0) begin
        err_term = err_term + 64'd4 * (rx_sq - grad_y);
      end else begin
        pen_x    = pen_x + 64'd1;
        grad_x   = grad_x + 64'd2 * ry_sq;
        err_term = err_term + 64'd4 * (grad_x - grad_y + rx_sq);
      end
    end
    r.valid_res = 1'b1;
    sum = ctr_x + pen_x;
    r.right_x = sum[OB-1:0];
    sum = ctr_x - pen_x;
    r.left_x = sum[OB-1:0];
    sum = ctr_y + pen_y;
    r.upper_y = sum[OB-1:0];
    sum = ctr_y - pen_y;
    r.lower_y = sum[OB-1:0];
    r.final_res = (pen_y == 64'd0);
    if (pen_y == 64'd0) tracing = 1'b0;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic signed [31:0] exp_v,
                               input logic signed [31:0] got_v);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    mismatch_count++;
  endtask

  task automatic add_row(input logic op, input int rx, input int ry, input int cx,
                         input int cy, input logic typed, input int v, input int rgt,
                         input int lft, input int upr, input int lwr, input int fin);
    plan_row_t row;
    row.op              = op;
    row.rx              = RB'(rx);
    row.ry              = RB'(ry);
    row.cx              = CB'(cx);
    row.cy              = CB'(cy);
    row.typed           = typed;
    row.known.valid_res = 1'(v);
    row.known.right_x   = OB'(rgt);
    row.known.left_x    = OB'(lft);
    row.known.upper_y   = OB'(upr);
    row.known.lower_y   = OB'(lwr);
    row.known.final_res = 1'(fin);
    plan.push_back(row);
  endtask

  // Offer one item, wait for it to be taken, and queue its point set
  task automatic send_item(input logic op, input logic [RB-1:0] rx,
                           input logic [RB-1:0] ry, input logic [CB-1:0] cx,
                           input logic [CB-1:0] cy, input logic typed,
                           input point_set_t known);
    point_set_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_W - 2 * RB - 2 * CB){1'b0}}, cy, cx, ry, rx};
    do @(posedge clk); while (!in_tready);
    pred = trace_ellipse(op, rx, ry, cx, cy);
    pending_sets.push_back(typed ? known : pred);
    last_set = pred;
    items_sent++;
    @(negedge clk);
  endtask

  // One random ellipse: start, then steps to the end, an abort, or stray steps
  task automatic random_sequence();
    int            pick;
    int            cap;
    bit            broad;
    logic [RB-1:0] rx, ry;
    pick  = $urandom_range(0, 99);
    broad = 1'b0;
    if (pick < 10) begin
      send_item(OP_STEP, RB'($urandom), RB'($urandom), CB'($urandom), CB'($urandom),
                1'b0, '0);
      return;
    end
    if (pick < 65) begin
      rx = RB'($urandom_range(0, 12));
      ry = RB'($urandom_range(0, 12));
    end else if (pick < 85) begin
      rx = RB'($urandom_range(0, 40));
      ry = RB'($urandom_range(0, 40));
    end else begin
      rx    = RB'($urandom_range(0, (1 << RB) - 1));
      ry    = RB'($urandom_range(0, (1 << RB) - 1));
      broad = 1'b1;
    end
    send_item(OP_START, rx, ry, CB'($urandom), CB'($urandom), 1'b0, '0);
    // Big radii are only walked a short way before the next start drops them
    if (broad) cap = $urandom_range(1, 20);
    else if ($urandom_range(0, 99) < 15) cap = $urandom_range(0, 6);
    else cap = 400;
    while (!last_set.final_res && cap > 0) begin
      send_item(OP_STEP, RB'($urandom), RB'($urandom), CB'($urandom), CB'($urandom),
                1'b0, '0);
      cap--;
    end
    if (last_set.final_res && $urandom_range(0, 99) < 30) begin
      repeat ($urandom_range(1, 2))
        send_item(OP_STEP, RB'($urandom), RB'($urandom), CB'($urandom), CB'($urandom),
                  1'b0, '0);
    end
  endtask

  // Receiver: random backpressure, plus one long hold on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (200) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Check each point set against the oldest one queued
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.valid_res = out_tuser;
      seen.right_x   = out_tdata[OB-1:0];
      seen.left_x    = out_tdata[2*OB-1:OB];
      seen.upper_y   = out_tdata[3*OB-1:2*OB];
      seen.lower_y   = out_tdata[4*OB-1:3*OB];
      seen.final_res = out_tlast;
      if (pending_sets.size() == 0) begin
        flag_mismatch("queued point sets", 32'sd0, 32'sd1);
      end else begin
        want = pending_sets.pop_front();
        if (seen.valid_res !== want.valid_res)
          flag_mismatch("valid_res", 32'(want.valid_res), 32'(seen.valid_res));
        if (seen.right_x !== want.right_x)
          flag_mismatch("right_x", 32'(want.right_x), 32'(seen.right_x));
        if (seen.left_x !== want.left_x)
          flag_mismatch("left_x", 32'(want.left_x), 32'(seen.left_x));
        if (seen.upper_y !== want.upper_y)
          flag_mismatch("upper_y", 32'(want.upper_y), 32'(seen.upper_y));
        if (seen.lower_y !== want.lower_y)
          flag_mismatch("lower_y", 32'(want.lower_y), 32'(seen.lower_y));
        if (seen.final_res !== want.final_res)
          flag_mismatch("final_res", 32'(want.final_res), 32'(seen.final_res));
      end
    end
  end

  // Main sequence
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = 1'b0;
    in_tdata  = '0;
    lower_arc = 1'b0;
    tracing   = 1'b0;
    pen_x = '0; pen_y = '0; grad_x = '0; grad_y = '0; err_term = '0;
    rx_sq = '0; ry_sq = '0; ctr_x = '0; ctr_y = '0;

    // Step while idle, zero vertical radius, extremes, start while busy,
    // zero horizontal radius, and a full small walk through both regions
    add_row(OP_STEP,     0,    0,     0,     0, 1, 0,     0,     0,     0,     0, 0);
    add_row(OP_START,    5,    0,   100,   -50, 1, 1,   100,   100,   -50,   -50, 1);
    add_row(OP_STEP,     0,    0,     0,     0, 1, 0,     0,     0,     0,     0, 0);
    add_row(OP_START, 1023, 1023,  2047, -2048, 1, 1,  2047,  2047, -1025, -3071, 0);
    add_row(OP_STEP,  1023, 1023,  2047,  2047, 0, 0,     0,     0,     0,     0, 0);
    add_row(OP_STEP,     0,    0, -2048, -2048, 0, 0,     0,     0,     0,     0, 0);
    add_row(OP_START,    0,    3, -2048,  2047, 1, 1, -2048, -2048,  2050,  2044, 0);
    add_row(OP_STEP,     0,    0,     0,     0, 0, 0,     0,     0,     0,     0, 0);
    add_row(OP_STEP,     0,    0,     0,     0, 0, 0,     0,     0,     0,     0, 0);
    add_row(OP_STEP,     0,    0,     0,     0, 0, 0,     0,     0,     0,     0, 0);
    add_row(OP_STEP,     0,    0,     0,     0, 1, 0,     0,     0,     0,     0, 0);
    add_row(OP_START,    7,    4,    -1,     1, 1, 1,    -1,    -1,     5,    -3, 0);
    repeat (12) add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i])
      send_item(plan[i].op, plan[i].rx, plan[i].ry, plan[i].cx, plan[i].cy,
                plan[i].typed, plan[i].known);

    // Three idle patterns; the last one also gets the long output hold
    for (int phase = 0; phase < 3; phase++) begin
      int target;
      case (phase)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      target = items_sent + 150;
      while (items_sent < target) random_sequence();
    end

    in_tvalid <= 1'b0;
    while (pending_sets.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("midpoint_ellipse_rasterizer_top regression: pass");
    end else begin
      $display("midpoint_ellipse_rasterizer_top regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("midpoint_ellipse_rasterizer_top regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
design/mer_pkg.sv
design/mer_ctrl.sv
design/mer_datapath.sv
design/midpoint_ellipse_rasterizer_top.sv
verif/tb_top.sv
